// File: hw/rtl/brq_pkg.sv
// brq_pkg: shared types, constants and popcount helper for the bit vector rank block
// no dependencies; used by brq_front, brq_queue, brq_back and bitvector_rank_query
`timescale 1ns / 1ps
`default_nettype none

package brq_pkg;

  localparam int BLOCK_W = 8;
  localparam int OFF_W   = 3;
  localparam int POS_W   = 14;
  localparam int BLK_W   = POS_W - OFF_W;
  localparam int POP_W   = 4;
  localparam int Q_DEPTH = 2;

  localparam logic [POS_W-1:0] COUNT_MAX = {POS_W{1'b1}};

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // one classified query waiting for the back end
  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] off;
    logic [BLK_W-1:0] blk;
  } query_t;

  // set bits among bits 0..off of a block
  function automatic logic [POP_W-1:0] pop_upto(input logic [BLOCK_W-1:0] bits,
                                                input logic [OFF_W-1:0] off);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < BLOCK_W; i++) begin
      if (OFF_W'(i) <= off) begin
        n = n + POP_W'(bits[i]);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/brq_ram.sv
// brq_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module brq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/brq_front.sv
// brq_front: accepts items, appends loaded blocks with their prefix counts,
// classifies rank queries for the back end; uses brq_pkg
`timescale 1ns / 1ps
`default_nettype none

module brq_front #(
  parameter int MAX_BLOCKS = 1024,
  parameter int AW         = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [brq_pkg::POS_W-1:0]   cfg_wdata,
  input  wire logic                        accept,
  input  wire logic                        cmd,
  input  wire logic [brq_pkg::BLOCK_W-1:0] block_bits,
  input  wire logic [brq_pkg::POS_W-1:0]   position,
  output logic                             ram_we,
  output logic [AW-1:0]                    ram_waddr,
  output logic [brq_pkg::BLOCK_W+brq_pkg::POS_W-1:0] ram_wdata,
  output logic                             push_valid,
  output brq_pkg::query_t                  push_data
);

  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int CMPW = (CW > brq_pkg::BLK_W) ? CW : brq_pkg::BLK_W;

  logic [brq_pkg::POS_W-1:0] total_bits;
  logic [CW-1:0]             blocks_loaded;
  logic [brq_pkg::POS_W-1:0] running_count;
  logic [brq_pkg::POS_W-1:0] running_count_next;
  logic [brq_pkg::POS_W:0]   run_sum;
  logic [brq_pkg::POS_W-1:0] k_m1;
  logic                      store_full;
  logic                      do_load;

  assign store_full = (blocks_loaded == CW'(MAX_BLOCKS));
  assign do_load    = accept && (cmd == brq_pkg::CMD_LOAD) && !store_full;

  assign run_sum = {1'b0, running_count}
                 + (brq_pkg::POS_W + 1)'(brq_pkg::pop_upto(block_bits, 3'd7));
  assign running_count_next = (run_sum > {1'b0, brq_pkg::COUNT_MAX}) ?
                              brq_pkg::COUNT_MAX : run_sum[brq_pkg::POS_W-1:0];

  assign ram_we    = do_load;
  assign ram_waddr = AW'(blocks_loaded);
  assign ram_wdata = {block_bits, running_count};

  // position k maps to block (k-1)/8 and offset (k-1)%8
  assign k_m1 = position - brq_pkg::POS_W'(1);

  always_comb begin
    push_valid    = accept && (cmd == brq_pkg::CMD_QUERY);
    push_data.off = k_m1[brq_pkg::OFF_W-1:0];
    push_data.blk = k_m1[brq_pkg::POS_W-1:brq_pkg::OFF_W];
    push_data.ok  = (position != '0) && (position <= total_bits)
                 && (CMPW'(push_data.blk) < CMPW'(blocks_loaded));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_bits    <= '0;
      blocks_loaded <= '0;
      running_count <= '0;
    end else begin
      if (cfg_we) begin
        total_bits <= cfg_wdata;
      end
      if (do_load) begin
        blocks_loaded <= blocks_loaded + CW'(1);
        running_count <= running_count_next;
      end
    end
  end

  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    blocks_loaded <= CW'(MAX_BLOCKS))
    else $error("block count beyond store depth");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> running_count >= $past(running_count))
    else $error("running count went down");

endmodule

`default_nettype wire

// File: hw/rtl/brq_queue.sv
// brq_queue: short fifo of classified queries between front and back end
// uses brq_pkg
`timescale 1ns / 1ps
`default_nettype none

module brq_queue (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push_valid,
  input  wire brq_pkg::query_t push_data,
  output logic         full,
  output logic         pop_valid,
  input  wire logic    pop_ready,
  output brq_pkg::query_t pop_data
);

  localparam int PW = (brq_pkg::Q_DEPTH > 1) ? $clog2(brq_pkg::Q_DEPTH) : 1;
  localparam int NW = $clog2(brq_pkg::Q_DEPTH + 1);

  brq_pkg::query_t entries [brq_pkg::Q_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == NW'(brq_pkg::Q_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(brq_pkg::Q_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(brq_pkg::Q_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> !full)
    else $error("query pushed into a full queue");

endmodule

`default_nettype wire

// File: hw/rtl/brq_back.sv
// brq_back: reads block and prefix for each in-range query, adds the partial popcount,
// holds the result in an output register; uses brq_pkg
`timescale 1ns / 1ps
`default_nettype none

module brq_back #(
  parameter int AW = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      pop_valid,
  output logic                           pop_ready,
  input  wire brq_pkg::query_t           pop_data,
  output logic                           ram_re,
  output logic [AW-1:0]                  ram_raddr,
  input  wire logic [brq_pkg::BLOCK_W+brq_pkg::POS_W-1:0] ram_rdata,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [brq_pkg::POS_W-1:0]      rank_value,
  output logic                           rank_valid
);

  logic                       s1_valid;
  logic                       s1_ok;
  logic [brq_pkg::OFF_W-1:0]  s1_off;
  logic                       s1_adv;
  logic [brq_pkg::BLOCK_W-1:0] rd_block;
  logic [brq_pkg::POS_W-1:0]  rd_prefix;
  logic [brq_pkg::POS_W:0]    sum;
  logic [brq_pkg::POS_W-1:0]  sum_sat;

  assign s1_adv    = !out_valid || out_ready;
  assign pop_ready = !s1_valid || s1_adv;
  // ram output holds while the read stage stalls since no new read is issued
  assign ram_re    = pop_valid && pop_ready && pop_data.ok;
  assign ram_raddr = AW'(pop_data.blk);

  assign rd_block  = ram_rdata[brq_pkg::BLOCK_W+brq_pkg::POS_W-1:brq_pkg::POS_W];
  assign rd_prefix = ram_rdata[brq_pkg::POS_W-1:0];
  assign sum = {1'b0, rd_prefix}
             + (brq_pkg::POS_W + 1)'(brq_pkg::pop_upto(rd_block, s1_off));
  assign sum_sat = (sum > {1'b0, brq_pkg::COUNT_MAX}) ?
                   brq_pkg::COUNT_MAX : sum[brq_pkg::POS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop_ready) begin
        s1_valid <= pop_valid;
      end
      if (s1_valid && s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      s1_ok  <= pop_data.ok;
      s1_off <= pop_data.off;
    end
    if (s1_valid && s1_adv) begin
      rank_valid <= s1_ok;
      rank_value <= s1_ok ? sum_sat : '0;
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rank_valid |-> rank_value == '0)
    else $error("invalid rank result carries a non-zero value");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_adv |=> out_valid)
    else $error("read stage advanced without filling output register");

endmodule

`default_nettype wire

// File: hw/rtl/bitvector_rank_query.sv
// bitvector_rank_query: top level, rank over a bit vector loaded as 8-bit blocks
// depends on brq_pkg, brq_front, brq_queue, brq_back, brq_ram
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | cmd, block_bits, position
//   out     | output    | out_valid / out_ready| rank_value, rank_valid
//   cfg     | input     | cfg_we (no wait)     | cfg_wdata -> total_bits
//
// one item per cycle is accepted while the two entry query queue has room
// a load is written to the block ram in the cycle it is accepted, unless the store is full, and gives no result
// a query result passes through the queue, the ram read and the output register before it appears
// the single ram read port sets the rate of queries to one per cycle while the output is not stalled
// reset clears counters and handshake state; the ram is not cleared, since
// queries only read blocks already loaded
`timescale 1ns / 1ps
`default_nettype none

module bitvector_rank_query #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [brq_pkg::POS_W-1:0]   cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        cmd,
  input  wire logic [brq_pkg::BLOCK_W-1:0] block_bits,
  input  wire logic [brq_pkg::POS_W-1:0]   position,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [brq_pkg::POS_W-1:0]        rank_value,
  output logic                             rank_valid
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int RW = brq_pkg::BLOCK_W + brq_pkg::POS_W;

  logic            accept;
  logic            q_full;
  logic            push_valid;
  brq_pkg::query_t push_data;
  logic            pop_valid;
  logic            pop_ready;
  brq_pkg::query_t pop_data;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [RW-1:0]   ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [RW-1:0]   ram_rdata;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  brq_front #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .AW         (AW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .cmd        (cmd),
    .block_bits (block_bits),
    .position   (position),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  brq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // block contents and prefix count share one word per block
  brq_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_BLOCKS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  brq_back #(
    .AW (AW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rank_value (rank_value),
    .rank_valid (rank_valid)
  );

endmodule

`default_nettype wire
